// ===== hw/rtl/cmps_pkg.sv =====
// Shared constants, types and helper functions for the cat-map PC scrambler.
// Used by cmps_divider, cat_map_pc_scrambler_top, the checker and the testbench. No dependencies.
`timescale 1ns / 1ps

package cmps_pkg;

   localparam int GRID_SIDE      = 9;
   localparam int FORWARD_ROUNDS = 5;
   localparam int INVERSE_ROUNDS = 7;
   localparam int GRID_CELLS     = GRID_SIDE * GRID_SIDE;

   localparam int SIDE_W   = 4;
   localparam int CELL_W   = 8;
   localparam int PC_W     = 7;
   localparam int ROUND_W  = 4;
   localparam int ADDR_W   = 16;
   localparam int STRIDE_W = 4;

   localparam int DIV_STEPS = ADDR_W;
   localparam int DIV_CNT_W = 4;

   localparam logic [ADDR_W-1:0]   OFFSET_RESET = 16'h0240;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'h9;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_STRIDE  = 1'b1;

   localparam logic OP_ADVANCE  = 1'b0;
   localparam logic OP_REDIRECT = 1'b1;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // v < 3*GRID_SIDE: two conditional subtracts
   function automatic logic [SIDE_W-1:0] mod_side(input logic [5:0] v);
      logic [5:0] g1;
      logic [5:0] g2;
      logic [5:0] r;
      g1 = 6'(GRID_SIDE);
      g2 = 6'(2 * GRID_SIDE);
      if (v >= g2) begin
         r = v - g2;
      end else if (v >= g1) begin
         r = v - g1;
      end else begin
         r = v;
      end
      return r[SIDE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/cmps_divider.sv =====
// Bit-serial restoring divider, 16-bit dividend by 4-bit divisor.
// Depends on cmps_pkg.
`timescale 1ns / 1ps

module cmps_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  cmps_pkg::div_ctl_type           ctl,
   input  logic [cmps_pkg::ADDR_W-1:0]     dividend,
   input  logic [cmps_pkg::STRIDE_W-1:0]   divisor,
   output cmps_pkg::div_stat_type          stat,
   output logic [cmps_pkg::ADDR_W-1:0]     quotient,
   output logic [cmps_pkg::STRIDE_W-1:0]   remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cmps_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [cmps_pkg::ADDR_W-1:0]       quo_ff, quo_in;
   logic [cmps_pkg::STRIDE_W-1:0]     rem_ff, rem_in;
   logic [cmps_pkg::STRIDE_W-1:0]     dsr_ff, dsr_in;
   logic [cmps_pkg::STRIDE_W:0]       trial;
   logic                              fits;

   assign trial = {rem_ff, quo_ff[cmps_pkg::ADDR_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[cmps_pkg::ADDR_W-2:0], fits};
         rem_in = fits ? cmps_pkg::STRIDE_W'(trial - {1'b0, dsr_ff})
                       : trial[cmps_pkg::STRIDE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cmps_pkg::DIV_CNT_W'(cmps_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/cat_map_pc_scrambler_top.sv =====
// Top level of the cat-map PC scrambler: sequencer, cat-map round unit, output register.
// Depends on cmps_pkg and cmps_divider.
`timescale 1ns / 1ps

// Keeps a virtual PC on a 9x9 grid and returns a scrambled fetch address per
// beat. One beat is in work at a time; req_tready is high only while idle. An
// advance splits the counter into grid coordinates by repeated subtraction, runs
// one cat-map round at a time on the shared round unit, then scale, offset and
// result. A redirect runs the bit-serial stride divider before the split, then
// 7 rounds, and skips scale and offset; a faulting redirect goes to result
// straight from idle or after the divider.
// A finished beat waits in the output register while the next one is taken.
module cat_map_pc_scrambler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] target_address
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] jump_address, [22:16] virtual_count, [23] zero
   output logic [0:0]  rsp_tuser    // [0] fault
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIVIDE = 7'b0000010,
      ST_SPLIT  = 7'b0000100,
      ST_ROUND  = 7'b0001000,
      ST_SCALE  = 7'b0010000,
      ST_OFFSET = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

   localparam int AW = cmps_pkg::ADDR_W;
   localparam int SW = cmps_pkg::SIDE_W;
   localparam int CW = cmps_pkg::CELL_W;
   localparam int PW = cmps_pkg::PC_W;
   localparam int RW = cmps_pkg::ROUND_W;
   localparam int TW = cmps_pkg::STRIDE_W;
   localparam int MW = CW + TW;

   state_type           state_ff, state_in;
   logic [AW-1:0]       offset_ff, offset_in;
   logic [TW-1:0]       stride_ff, stride_in;
   logic [PW-1:0]       pc_ff, pc_in;
   logic                op_ff, op_in;
   logic [AW-1:0]       target_ff, target_in;
   logic                fault_ff, fault_in;
   logic [CW-1:0]       slot_ff, slot_in;
   logic [SW-1:0]       x_ff, x_in;
   logic [SW-1:0]       y_ff, y_in;
   logic [RW-1:0]       round_ff, round_in;
   logic [MW-1:0]       prod_ff, prod_in;
   logic [AW-1:0]       jump_ff, jump_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       rsp_jump_ff, rsp_jump_in;
   logic [PW-1:0]       rsp_count_ff, rsp_count_in;
   logic                rsp_fault_ff, rsp_fault_in;

   cmps_pkg::div_ctl_type  div_ctl;
   cmps_pkg::div_stat_type div_stat;
   logic [AW-1:0]          div_quo;
   logic [TW-1:0]          div_rem;

   logic                   req_accept;
   logic [CW-1:0]          pc_plus;
   logic [PW-1:0]          pc_next;
   logic [CW-1:0]          slot_join;
   logic [RW-1:0]          round_lim;
   logic [SW-1:0]          x_step, y_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign pc_plus   = {1'b0, pc_ff} + 1'b1;
   assign pc_next   = (pc_plus >= CW'(cmps_pkg::GRID_CELLS)) ? '0 : pc_plus[PW-1:0];
   assign slot_join = CW'(CW'(cmps_pkg::GRID_SIDE) * {{(CW-SW){1'b0}}, x_ff})
                      + {{(CW-SW){1'b0}}, y_ff};
   assign round_lim = (op_ff == cmps_pkg::OP_REDIRECT) ? RW'(cmps_pkg::INVERSE_ROUNDS)
                                                       : RW'(cmps_pkg::FORWARD_ROUNDS);
   assign x_step = cmps_pkg::mod_side({1'b0, x_ff, 1'b0} + {2'b00, y_ff});
   assign y_step = cmps_pkg::mod_side({2'b00, x_ff} + {2'b00, y_ff});

   cmps_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (target_ff - offset_ff),
      .divisor   (stride_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      stride_in    = stride_ff;
      pc_in        = pc_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      fault_in     = fault_ff;
      slot_in      = slot_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      round_in     = round_ff;
      prod_in      = prod_ff;
      jump_in      = jump_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_jump_in  = rsp_jump_ff;
      rsp_count_in = rsp_count_ff;
      rsp_fault_in = rsp_fault_ff;
      div_ctl.start = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            cmps_pkg::CSR_BASE_OFFSET: offset_in = csr_wdata;
            cmps_pkg::CSR_PAD_STRIDE:  stride_in = csr_wdata[TW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_tuser[0];
               target_in = req_tdata;
               fault_in  = 1'b0;
               x_in      = '0;
               jump_in   = req_tdata;
               if (req_tuser[0] == cmps_pkg::OP_ADVANCE) begin
                  pc_in    = pc_next;
                  slot_in  = {1'b0, pc_next};
                  state_in = ST_SPLIT;
               end else if (stride_ff == '0 || req_tdata < offset_ff) begin
                  fault_in = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (!div_stat.busy && !div_stat.done) begin
               div_ctl.start = 1'b1;
            end else if (div_stat.done) begin
               slot_in = div_quo[CW-1:0];
               if (div_rem != '0 || div_quo >= AW'(cmps_pkg::GRID_CELLS)) begin
                  fault_in = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (slot_ff >= CW'(cmps_pkg::GRID_SIDE)) begin
               slot_in = slot_ff - CW'(cmps_pkg::GRID_SIDE);
               x_in    = x_ff + 1'b1;
            end else begin
               y_in     = slot_ff[SW-1:0];
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == round_lim) begin
               if (op_ff == cmps_pkg::OP_REDIRECT) begin
                  pc_in    = slot_join[PW-1:0];
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCALE;
               end
            end else begin
               x_in     = x_step;
               y_in     = y_step;
               round_in = round_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            prod_in  = MW'(MW'(slot_join) * MW'(stride_ff));
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            jump_in  = offset_ff + AW'(prod_ff);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_jump_in  = jump_ff;
               rsp_count_in = pc_ff;
               rsp_fault_in = fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= cmps_pkg::OFFSET_RESET;
         stride_ff    <= cmps_pkg::STRIDE_RESET;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         stride_ff    <= stride_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      target_ff    <= target_in;
      fault_ff     <= fault_in;
      slot_ff      <= slot_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      round_ff     <= round_in;
      prod_ff      <= prod_in;
      jump_ff      <= jump_in;
      rsp_jump_ff  <= rsp_jump_in;
      rsp_count_ff <= rsp_count_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_count_ff, rsp_jump_ff};
   assign rsp_tuser[0] = rsp_fault_ff;

   // divider only runs while the sequencer waits on it
   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == ST_DIVIDE))
      else $error("divider active outside divide state");

   // only a redirect can fault
   a_fault_redirect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && fault_ff) |-> (op_ff == cmps_pkg::OP_REDIRECT))
      else $error("fault raised on advance");

   // counter stays on the grid
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pc_ff} < CW'(cmps_pkg::GRID_CELLS)) || (cmps_pkg::GRID_CELLS > 128))
      else $error("virtual pc off grid");

   // a finished beat is never dropped while unread
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_jump_ff)))
      else $error("pending response lost");

endmodule

// ===== test/cat_map_pc_scrambler_checker.sv =====
// Checker for the cat-map PC scrambler: watches the CSR port and both streams,
// predicts each response beat and compares it field by field. Depends on cmps_pkg.
`timescale 1ns / 1ps

module cat_map_pc_scrambler_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] target_address
   input  logic [0:0]  req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [15:0] jump_address, [22:16] virtual_count, [23] zero
   input  logic [0:0]  rsp_tuser,   // [0] fault
   output int          error_count,
   output int          beats_in,
   output int          beats_out,
   output int          fault_beats
);

   typedef struct packed {
      logic [15:0] jump;
      logic [6:0]  count;
      logic        fault;
   } xlate_type;

   xlate_type                     fetch_queue[$];
   logic [cmps_pkg::ADDR_W-1:0]   offset_q;
   logic [cmps_pkg::STRIDE_W-1:0] stride_q;
   logic [cmps_pkg::PC_W-1:0]     vpc_q;
   int                            errs;
   int                            n_in;
   int                            n_out;
   int                            n_fault;

   function automatic int cat_walk(input int slot, input int rounds);
      int x;
      int y;
      int nx;
      x = slot / cmps_pkg::GRID_SIDE;
      y = slot % cmps_pkg::GRID_SIDE;
      for (int r = 0; r < rounds; r++) begin
         nx = (2 * x + y) % cmps_pkg::GRID_SIDE;
         y  = (x + y) % cmps_pkg::GRID_SIDE;
         x  = nx;
      end
      return cmps_pkg::GRID_SIDE * x + y;
   endfunction

   function automatic xlate_type translate_beat(input logic op, input logic [15:0] tgt,
                                                input logic [6:0] pc, input logic [15:0] offs,
                                                input logic [3:0] stride);
      xlate_type r;
      int        nxt;
      int        span;
      r.fault = 1'b0;
      r.count = pc;
      if (op == cmps_pkg::OP_ADVANCE) begin
         nxt = int'(pc) + 1;
         if (nxt >= cmps_pkg::GRID_CELLS) nxt = 0;
         r.count = 7'(nxt);
         r.jump  = 16'(cat_walk(int'(r.count), cmps_pkg::FORWARD_ROUNDS) * int'(stride)
                       + int'(offs));
      end else begin
         r.jump = tgt;
         if (stride == 0 || tgt < offs) begin
            r.fault = 1'b1;
         end else begin
            span = int'(tgt) - int'(offs);
            if (span % int'(stride) != 0 || span / int'(stride) >= cmps_pkg::GRID_CELLS) begin
               r.fault = 1'b1;
            end else begin
               r.count = 7'(cat_walk(span / int'(stride), cmps_pkg::INVERSE_ROUNDS));
            end
         end
      end
      return r;
   endfunction

   task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] got);
      errs++;
      if (errs <= 40) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      xlate_type want;
      xlate_type got;
      if (reset) begin
         offset_q = cmps_pkg::OFFSET_RESET;
         stride_q = cmps_pkg::STRIDE_RESET;
         vpc_q    = '0;
         errs     = 0;
         n_in     = 0;
         n_out    = 0;
         n_fault  = 0;
         fetch_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               cmps_pkg::CSR_BASE_OFFSET: offset_q = csr_wdata;
               cmps_pkg::CSR_PAD_STRIDE:  stride_q = csr_wdata[cmps_pkg::STRIDE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = translate_beat(req_tuser[0], req_tdata, vpc_q, offset_q, stride_q);
            vpc_q = want.count;
            fetch_queue.push_back(want);
            n_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_out++;
            if (fetch_queue.size() == 0) begin
               errs++;
               if (errs <= 40) begin
                  $display("%0t: response beat with nothing pending, expected none, got %h/%h",
                           $time, rsp_tdata, rsp_tuser);
               end
            end else begin
               want      = fetch_queue.pop_front();
               got.jump  = rsp_tdata[15:0];
               got.count = rsp_tdata[22:16];
               got.fault = rsp_tuser[0];
               if (want.fault) n_fault++;
               if (got.jump !== want.jump) flag_field("jump_address", want.jump, got.jump);
               if (got.count !== want.count) flag_field("virtual_count", want.count, got.count);
               if (got.fault !== want.fault) flag_field("fault", want.fault, got.fault);
               if (rsp_tdata[23] !== 1'b0) flag_field("tdata pad bit", 0, rsp_tdata[23]);
            end
         end
      end
      error_count <= errs;
      beats_in    <= n_in;
      beats_out   <= n_out;
      fault_beats <= n_fault;
   end

endmodule

// ===== test/testbench.sv =====
// Top of the cat-map PC scrambler testbench: clock, reset, stimulus, verdict.
// Depends on cmps_pkg, cat_map_pc_scrambler_top and cat_map_pc_scrambler_checker.
`timescale 1ns / 1ps

module testbench;

   // grid slot 1 decodes to counter 80, the last one before the wrap
   localparam int SLOT_OF_LAST_PC = 1;
   localparam int PHASE_BEATS     = 120;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   int error_count;
   int beats_in;
   int beats_out;
   int fault_beats;
   int tx_idle_pct = 28;
   int rx_idle_pct = 55;
   logic [15:0] cur_offset = cmps_pkg::OFFSET_RESET;
   logic [3:0]  cur_stride = cmps_pkg::STRIDE_RESET;

   cat_map_pc_scrambler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cat_map_pc_scrambler_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .error_count (error_count),
      .beats_in    (beats_in),
      .beats_out   (beats_out),
      .fault_beats (fault_beats)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   task automatic send_beat(input logic op, input logic [15:0] tgt);
      bit got_ready;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= tgt;
      do begin
         @(negedge clock);
         got_ready = req_tready;
         @(posedge clock);
      end while (!got_ready);
   endtask

   task automatic drain_rsp();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (beats_in != beats_out && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] offs, input logic [3:0] stride);
      csr_we     <= 1'b1;
      csr_index  <= cmps_pkg::CSR_BASE_OFFSET;
      csr_wdata  <= offs;
      @(posedge clock);
      csr_index  <= cmps_pkg::CSR_PAD_STRIDE;
      csr_wdata  <= 16'(stride);
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_offset = offs;
      cur_stride = stride;
      @(posedge clock);
   endtask

   function automatic logic [15:0] slot_addr(input int slot);
      return 16'(int'(cur_offset) + slot * int'(cur_stride));
   endfunction

   task automatic random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_beat(cmps_pkg::OP_ADVANCE, 16'($urandom));
      end else if (pick < 80) begin
         send_beat(cmps_pkg::OP_REDIRECT, slot_addr($urandom_range(0, cmps_pkg::GRID_CELLS - 1)));
      end else if (pick < 85) begin
         send_beat(cmps_pkg::OP_REDIRECT,
                   slot_addr($urandom_range(0, cmps_pkg::GRID_CELLS - 1)) + 16'd1);
      end else if (pick < 90) begin
         send_beat(cmps_pkg::OP_REDIRECT,
                   slot_addr(cmps_pkg::GRID_CELLS + $urandom_range(0, 3)));
      end else begin
         send_beat(cmps_pkg::OP_REDIRECT, 16'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, then grid corners, address wrap, zero stride
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      send_beat(cmps_pkg::OP_ADVANCE, 16'hFFFF);
      send_beat(cmps_pkg::OP_REDIRECT, slot_addr(0));
      send_beat(cmps_pkg::OP_REDIRECT, slot_addr(SLOT_OF_LAST_PC));
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      send_beat(cmps_pkg::OP_REDIRECT, cur_offset - 16'd1);
      send_beat(cmps_pkg::OP_REDIRECT, cur_offset + 16'd1);
      send_beat(cmps_pkg::OP_REDIRECT, slot_addr(cmps_pkg::GRID_CELLS - 1));
      send_beat(cmps_pkg::OP_REDIRECT, slot_addr(cmps_pkg::GRID_CELLS));
      send_beat(cmps_pkg::OP_REDIRECT, 16'h0000);
      send_beat(cmps_pkg::OP_REDIRECT, 16'hFFFF);
      send_beat(cmps_pkg::OP_ADVANCE, 16'hFFFF);
      drain_rsp();
      set_config(16'h0000, 4'd1);
      send_beat(cmps_pkg::OP_REDIRECT, 16'd0);
      send_beat(cmps_pkg::OP_REDIRECT, 16'(cmps_pkg::GRID_CELLS - 1));
      send_beat(cmps_pkg::OP_REDIRECT, 16'(cmps_pkg::GRID_CELLS));
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      drain_rsp();
      set_config(16'hFFFF, 4'd15);
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      send_beat(cmps_pkg::OP_REDIRECT, 16'hFFFF);
      send_beat(cmps_pkg::OP_REDIRECT, 16'hFFFE);
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      drain_rsp();
      set_config(16'h1234, 4'd0);
      send_beat(cmps_pkg::OP_ADVANCE, 16'h0000);
      send_beat(cmps_pkg::OP_REDIRECT, 16'h1234);
      send_beat(cmps_pkg::OP_REDIRECT, 16'h0000);

      for (int p = 0; p < 6; p++) begin
         drain_rsp();
         case (p / 2)
            0: begin tx_idle_pct = 28; rx_idle_pct = 55; end
            1: begin tx_idle_pct = 55; rx_idle_pct = 28; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         case (p)
            0: set_config(cmps_pkg::OFFSET_RESET, cmps_pkg::STRIDE_RESET);
            1: set_config(16'h0000, 4'd1);
            2: set_config(16'hFFFF, 4'd15);
            3: set_config(16'($urandom), 4'($urandom_range(0, 15)));
            4: set_config(16'($urandom_range(0, 16'hFE00)), 4'($urandom_range(1, 15)));
            default: set_config(16'hFC00, 4'd15);
         endcase
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (i == 40 && (p == 0 || p == 4)) begin
               repeat (cmps_pkg::GRID_CELLS + 4) send_beat(cmps_pkg::OP_ADVANCE, 16'($urandom));
            end
            if ($urandom_range(0, 99) == 0) drain_rsp();
            random_beat();
         end
      end

      drain_rsp();
      $display("Summary: %0d request beats, %0d response beats, %0d faulting redirects,",
               beats_in, beats_out, fault_beats);
      $display("  over 10 register settings, counter wrap and three stall patterns");
      if (error_count == 0 && beats_in == beats_out) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cmps_pkg.sv
hw/rtl/cmps_divider.sv
hw/rtl/cat_map_pc_scrambler_top.sv
test/cat_map_pc_scrambler_checker.sv
test/testbench.sv
